[design/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the run-length sprite clip blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int SURF_W     = 13;
  localparam int PIX_ADDR_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // full address before wrapping: y * pitch + x with 13-bit operands
  localparam int ADDR_FULL_W = 2 * SURF_W;

  // parameter defaults
  localparam int DEF_ADDR_BITS   = 24;
  localparam int DEF_QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH      = 3'd4;

  // configuration reset values
  localparam logic [SURF_W-1:0] RST_SURFACE_WIDTH  = 13'd320;
  localparam logic [SURF_W-1:0] RST_SURFACE_HEIGHT = 13'd200;
  localparam logic [SURF_W-1:0] RST_ROW_PITCH      = 13'd320;

  // stream constants
  localparam logic [31:0]       HDR_MARKER = 32'h0000_0002;
  localparam logic [BYTE_W-1:0] SKIP_BASE  = 8'h80;

  // work item from the front end to the back end
  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               is_pixel;
    logic               done;
  } entry_t;

endpackage

`default_nettype wire

[design/rsc_queue.sv]
// ----------------------------------------------------------------------------
// rsc_queue
// Short register queue between the decode front end and the pixel back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_queue #(
  parameter int DEPTH = rsc_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rsc_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output rsc_pkg::entry_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rsc_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/rsc_front.sv]
// ----------------------------------------------------------------------------
// rsc_front
// Byte decoder: header parse, skip and literal runs, sprite position
// tracking and end detection. Queues one entry per byte that has a result.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [rsc_pkg::BYTE_W-1:0]         stream_byte,
  input  wire logic                               start_of_bitmap,
  input  wire logic signed [rsc_pkg::COORD_W-1:0] dest_y,
  input  wire logic [rsc_pkg::SURF_W-1:0]         surface_height,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output rsc_pkg::entry_t                         q_data
);

  localparam logic [3:0] PH_WORD2 = 4'd4;
  localparam logic [3:0] PH_DATA  = 4'd8;

  // decoder state
  logic [3:0]                   header_phase, header_phase_next;
  logic [31:0]                  header_bytes, header_bytes_next;
  logic [rsc_pkg::COORD_W-1:0]  sprite_width, sprite_width_next;
  logic [31:0]                  pixels_left, pixels_left_next;
  logic [rsc_pkg::BYTE_W-1:0]   literal_left, literal_left_next;
  logic [rsc_pkg::COORD_W-1:0]  sprite_col, sprite_col_next;
  logic [rsc_pkg::COORD_W-1:0]  sprite_row, sprite_row_next;
  logic                         finished, finished_next;

  logic                         accept;
  logic [3:0]                   phase_eff;
  logic [31:0]                  hdr_eff;
  logic [3:0]                   phase_inc;
  logic [31:0]                  hdr_new;
  logic [6:0]                   step_n;
  logic [rsc_pkg::COORD_W:0]    col_sum;
  logic                         col_wrap;
  logic [rsc_pkg::COORD_W-1:0]  col_adv;
  logic [rsc_pkg::COORD_W-1:0]  row_adv;
  logic                         reaches_end;
  logic [31:0]                  left_adv;
  logic signed [17:0]           y_pos;
  logic                         is_skip;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // header accumulation, restarted by a start byte
  always_comb begin
    phase_eff = start_of_bitmap ? 4'd0 : header_phase;
    hdr_eff   = start_of_bitmap ? 32'd0 : header_bytes;
    phase_inc = phase_eff + 4'd1;
    hdr_new   = hdr_eff | (32'(stream_byte) << {phase_eff[1:0], 3'b000});
  end

  // position advance by a skip count or by one literal pixel
  always_comb begin
    step_n      = (literal_left == '0) ? stream_byte[6:0] : 7'd1;
    col_sum     = {1'b0, sprite_col} + 17'(step_n);
    col_wrap    = (col_sum >= {1'b0, sprite_width});
    col_adv     = col_wrap ? 16'(col_sum - {1'b0, sprite_width}) : col_sum[15:0];
    row_adv     = col_wrap ? sprite_row + 16'd1 : sprite_row;
    reaches_end = ({25'd0, step_n} >= pixels_left);
    left_adv    = pixels_left - 32'(step_n);
    is_skip     = stream_byte[7] &&
                  ({9'd0, stream_byte[6:0]} <= sprite_width);
    y_pos       = $signed({2'b00, sprite_row}) + $signed({{2{dest_y[15]}}, dest_y});
  end

  // next state and queue entry
  always_comb begin
    header_phase_next = header_phase;
    header_bytes_next = header_bytes;
    sprite_width_next = sprite_width;
    pixels_left_next  = pixels_left;
    literal_left_next = literal_left;
    sprite_col_next   = sprite_col;
    sprite_row_next   = sprite_row;
    finished_next     = finished;
    q_push            = 1'b0;
    q_data            = '0;

    if (accept && (start_of_bitmap || !finished)) begin
      if (start_of_bitmap) begin
        finished_next     = 1'b0;
        header_phase_next = '0;
        header_bytes_next = '0;
        sprite_width_next = '0;
        pixels_left_next  = '0;
        literal_left_next = '0;
        sprite_col_next   = '0;
        sprite_row_next   = '0;
      end

      if (phase_eff < PH_DATA) begin
        // header bytes
        if (phase_inc == PH_WORD2 && hdr_new == rsc_pkg::HDR_MARKER) begin
          header_bytes_next = '0;
          header_phase_next = PH_WORD2;
        end else if (phase_inc == PH_WORD2 || phase_inc == PH_DATA) begin
          sprite_width_next = hdr_new[15:0];
          pixels_left_next  = 32'(hdr_new[15:0]) * 32'(hdr_new[31:16]);
          header_phase_next = PH_DATA;
          if (hdr_new[15:0] == '0 || hdr_new[31:16] == '0) begin
            finished_next     = 1'b1;
            literal_left_next = '0;
            q_push            = 1'b1;
            q_data.done       = 1'b1;
          end
        end else begin
          header_phase_next = phase_inc;
          header_bytes_next = hdr_new;
        end
      end else if (literal_left == '0) begin
        // control byte
        if (is_skip) begin
          sprite_col_next  = col_adv;
          sprite_row_next  = row_adv;
          pixels_left_next = left_adv;
          if (reaches_end) begin
            finished_next = 1'b1;
            q_push        = 1'b1;
            q_data.done   = 1'b1;
          end
        end else begin
          literal_left_next = stream_byte;
        end
      end else begin
        // literal pixel byte
        literal_left_next = literal_left - 8'd1;
        if (y_pos >= $signed({5'b00000, surface_height})) begin
          finished_next     = 1'b1;
          literal_left_next = '0;
          q_push            = 1'b1;
          q_data.done       = 1'b1;
        end else begin
          sprite_col_next   = col_adv;
          sprite_row_next   = row_adv;
          pixels_left_next  = left_adv;
          q_push            = 1'b1;
          q_data.value      = stream_byte;
          q_data.col        = sprite_col;
          q_data.row        = sprite_row;
          q_data.is_pixel   = 1'b1;
          q_data.done       = reaches_end;
          if (reaches_end) begin
            finished_next     = 1'b1;
            literal_left_next = '0;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_phase <= '0;
      header_bytes <= '0;
      sprite_width <= '0;
      pixels_left  <= '0;
      literal_left <= '0;
      sprite_col   <= '0;
      sprite_row   <= '0;
      finished     <= 1'b1;
    end else begin
      header_phase <= header_phase_next;
      header_bytes <= header_bytes_next;
      sprite_width <= sprite_width_next;
      pixels_left  <= pixels_left_next;
      literal_left <= literal_left_next;
      sprite_col   <= sprite_col_next;
      sprite_row   <= sprite_row_next;
      finished     <= finished_next;
    end
  end

endmodule

`default_nettype wire

[design/rsc_back.sv]
// ----------------------------------------------------------------------------
// rsc_back
// Pixel back end: horizontal and top-edge clip, address multiply-add and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsc_back #(
  parameter int ADDR_BITS = rsc_pkg::DEF_ADDR_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_not_empty,
  input  wire rsc_pkg::entry_t                     q_head,
  output logic                                     q_pop,
  input  wire logic signed [rsc_pkg::COORD_W-1:0]  dest_x,
  input  wire logic signed [rsc_pkg::COORD_W-1:0]  dest_y,
  input  wire logic [rsc_pkg::SURF_W-1:0]          surface_width,
  input  wire logic [rsc_pkg::SURF_W-1:0]          row_pitch,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     write_enable,
  output logic [rsc_pkg::PIX_ADDR_W-1:0]           pixel_addr,
  output logic [rsc_pkg::BYTE_W-1:0]               pixel_value,
  output logic                                     bitmap_done
);

  localparam int FULL_W    = rsc_pkg::ADDR_FULL_W;
  localparam int KEEP_BITS = (ADDR_BITS < FULL_W) ? ADDR_BITS : FULL_W;
  localparam logic [FULL_W-1:0] ADDR_MASK = {FULL_W{1'b1}} >> (FULL_W - KEEP_BITS);

  logic signed [17:0]  x_pos;
  logic signed [17:0]  y_pos;
  logic                wr;
  logic                has_result;
  logic                load_ok;
  logic [FULL_W-1:0]   row_base;
  logic [FULL_W-1:0]   addr_full;

  // clip and address for the head entry
  always_comb begin
    x_pos      = $signed({2'b00, q_head.col}) + $signed({{2{dest_x[15]}}, dest_x});
    y_pos      = $signed({2'b00, q_head.row}) + $signed({{2{dest_y[15]}}, dest_y});
    wr         = q_head.is_pixel && !x_pos[17] && !y_pos[17] &&
                 (x_pos < $signed({5'b00000, surface_width}));
    has_result = wr || q_head.done;
    row_base   = FULL_W'(y_pos[rsc_pkg::SURF_W-1:0]) * FULL_W'(row_pitch);
    addr_full  = (row_base + FULL_W'(x_pos[rsc_pkg::SURF_W-1:0])) & ADDR_MASK;
    load_ok    = !out_valid || out_ready;
    q_pop      = q_not_empty && load_ok;
  end

  // output register, entries with nothing to show are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      write_enable <= wr;
      pixel_addr   <= wr ? addr_full[rsc_pkg::PIX_ADDR_W-1:0] : '0;
      pixel_value  <= wr ? q_head.value : '0;
      bitmap_done  <= q_head.done;
    end
  end

endmodule

`default_nettype wire

[design/rle_sprite_clip_blitter.sv]
// ----------------------------------------------------------------------------
// rle_sprite_clip_blitter
// Run-length 8-bpp transparent sprite decoder with surface clipping; issues
// framebuffer pixel writes for each visible literal pixel and a done result per bitmap.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid/in_ready     stream_byte, start_of_bitmap
//   out      source     out_valid/out_ready   write_enable, pixel_addr,
//                                             pixel_value, bitmap_done
//   cfg      sink       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while the queue is not full; a result is offered from the
// output register (decode and queue write at the byte transfer, then the address
// multiply-add on the queue head into the output register).
// The input stalls only when the queue between decoder and back end is full.
// Reset leaves the decoder finished, waiting for a start byte; configuration
// writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_sprite_clip_blitter #(
  parameter int ADDR_BITS   = rsc_pkg::DEF_ADDR_BITS,
  parameter int QUEUE_DEPTH = rsc_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rsc_pkg::BYTE_W-1:0]        stream_byte,
  input  wire logic                              start_of_bitmap,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   write_enable,
  output logic [rsc_pkg::PIX_ADDR_W-1:0]         pixel_addr,
  output logic [rsc_pkg::BYTE_W-1:0]             pixel_value,
  output logic                                   bitmap_done,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [rsc_pkg::COORD_W-1:0] dest_x;
  logic signed [rsc_pkg::COORD_W-1:0] dest_y;
  logic [rsc_pkg::SURF_W-1:0]         surface_width;
  logic [rsc_pkg::SURF_W-1:0]         surface_height;
  logic [rsc_pkg::SURF_W-1:0]         row_pitch;

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  rsc_pkg::entry_t q_push_data;
  rsc_pkg::entry_t q_head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x         <= '0;
      dest_y         <= '0;
      surface_width  <= rsc_pkg::RST_SURFACE_WIDTH;
      surface_height <= rsc_pkg::RST_SURFACE_HEIGHT;
      row_pitch      <= rsc_pkg::RST_ROW_PITCH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsc_pkg::REG_DEST_X:         dest_x         <= $signed(cfg_data);
        rsc_pkg::REG_DEST_Y:         dest_y         <= $signed(cfg_data);
        rsc_pkg::REG_SURFACE_WIDTH:  surface_width  <= cfg_data[rsc_pkg::SURF_W-1:0];
        rsc_pkg::REG_SURFACE_HEIGHT: surface_height <= cfg_data[rsc_pkg::SURF_W-1:0];
        rsc_pkg::REG_ROW_PITCH:      row_pitch      <= cfg_data[rsc_pkg::SURF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // decoder front end
  rsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .stream_byte     (stream_byte),
    .start_of_bitmap (start_of_bitmap),
    .dest_y          (dest_y),
    .surface_height  (surface_height),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_push_data)
  );

  // decoupling queue
  rsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // pixel back end
  rsc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .dest_x        (dest_x),
    .dest_y        (dest_y),
    .surface_width (surface_width),
    .row_pitch     (row_pitch),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_enable  (write_enable),
    .pixel_addr    (pixel_addr),
    .pixel_value   (pixel_value),
    .bitmap_done   (bitmap_done)
  );

endmodule

`default_nettype wire
